### hw/rtl/olist_pkg.sv
// olist_pkg: sizes, codes and request/result types for the ordered list.
// Used by the cell row, the read-out tree and the top level; depends on nothing.
`timescale 1ns / 1ps

package olist_pkg;

   localparam int LIST_DEPTH  = 128;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(LIST_DEPTH);
   localparam int COUNT_W     = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W       = (COUNT_W > 8) ? COUNT_W : 8;
   localparam int TREE_LEVELS = IDX_W;
   localparam int TREE_LEAVES = 1 << IDX_W;
   localparam int STEP_W      = $clog2(TREE_LEVELS + 1);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [7:0]        position;
      logic [DATA_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value_out;
      logic [1:0]        error_code;
      logic [7:0]        entry_count;
      logic              is_empty;
      logic              is_full;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic              read_en;
      logic [CMP_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

### hw/rtl/olist_cell.sv
// olist_cell: one list slot; holds an entry, shifts with its neighbors, taps on read.
// Depends on olist_pkg.
`timescale 1ns / 1ps

module olist_cell (
   input  logic                         clock,
   input  olist_pkg::cell_ctl_type      ctl,
   input  logic [olist_pkg::IDX_W-1:0]  idx,
   input  logic [olist_pkg::DATA_W-1:0] left_data,
   input  logic [olist_pkg::DATA_W-1:0] right_data,
   output logic [olist_pkg::DATA_W-1:0] data_out,
   output logic [olist_pkg::DATA_W-1:0] tap_out
);

   logic [olist_pkg::DATA_W-1:0] data_ff, data_in;
   logic [olist_pkg::DATA_W-1:0] tap_ff, tap_in;
   logic [olist_pkg::CMP_W-1:0]  idx_w;

   assign idx_w = olist_pkg::CMP_W'(idx);

   always_comb begin
      data_in = data_ff;
      unique case (ctl.op)
         olist_pkg::OP_INSERT: begin
            if (idx_w > ctl.pos) begin
               data_in = left_data;
            end else if (idx_w == ctl.pos) begin
               data_in = ctl.value;
            end
         end
         olist_pkg::OP_DELETE: begin
            if (idx_w >= ctl.pos) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   assign tap_in = (ctl.read_en && (idx_w == ctl.pos)) ? data_ff : '0;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tap_ff  <= tap_in;
   end

   assign data_out = data_ff;
   assign tap_out  = tap_ff;

endmodule

### hw/rtl/olist_or_tree.sv
// olist_or_tree: registered binary OR tree that gathers the single live cell tap.
// Depends on olist_pkg.
`timescale 1ns / 1ps

module olist_or_tree (
   input  logic                         clock,
   input  logic [olist_pkg::DATA_W-1:0] taps [olist_pkg::LIST_DEPTH],
   output logic [olist_pkg::DATA_W-1:0] root
);

   localparam int L = olist_pkg::TREE_LEAVES;

   logic [olist_pkg::DATA_W-1:0] leaf [L];
   logic [olist_pkg::DATA_W-1:0] node_ff [1:L-1];
   logic [olist_pkg::DATA_W-1:0] node_in [1:L-1];

   for (genvar j = 0; j < L; j++) begin : g_leaf
      if (j < olist_pkg::LIST_DEPTH) begin : g_used
         assign leaf[j] = taps[j];
      end else begin : g_pad
         assign leaf[j] = '0;
      end
   end

   for (genvar k = 1; k < L; k++) begin : g_node
      if (2 * k >= L) begin : g_bottom
         assign node_in[k] = leaf[2*k-L] | leaf[2*k+1-L];
      end else begin : g_inner
         assign node_in[k] = node_ff[2*k] | node_ff[2*k+1];
      end
      always_ff @(posedge clock) begin
         node_ff[k] <= node_in[k];
      end
   end

   assign root = node_ff[1];

endmodule

### hw/rtl/ordered_array_list.sv
// ordered_array_list: top level; request decode, count, row of cells, read-out tree.
// Depends on olist_pkg, olist_cell and olist_or_tree.
`timescale 1ns / 1ps
//
//   channel   ports                    direction  handshake
//   request   start, busy, req_data    in         taken when start & !busy
//   result    rsp_valid, rsp_data      out        one-cycle strobe, never held off
//
// For a request, the shift happens in the accept cycle, then the read value climbs
// the registered OR tree, one level per cycle, log2(LIST_DEPTH) levels. busy stays
// high from accept to the strobe.
// Synchronous reset empties the list; entry contents are not cleared.

module ordered_array_list (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  olist_pkg::req_type   req_data,
   output logic                 rsp_valid,
   output olist_pkg::rsp_type   rsp_data
);

   logic                              accept;
   logic                              busy_ff, busy_in;
   logic [olist_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [olist_pkg::COUNT_W-1:0]     count_ff, count_in;
   olist_pkg::err_type                err_ff, err_in;
   logic [olist_pkg::CMP_W-1:0]       pos_w, cnt_w;
   logic                              full, done;
   logic                              ok_ins, ok_del, ok_rd;
   olist_pkg::cell_ctl_type           ctl;
   logic [olist_pkg::DATA_W-1:0]      cell_data [olist_pkg::LIST_DEPTH];
   logic [olist_pkg::DATA_W-1:0]      taps [olist_pkg::LIST_DEPTH];
   logic [olist_pkg::DATA_W-1:0]      root;

   assign accept = start & ~busy_ff;
   assign pos_w  = olist_pkg::CMP_W'(req_data.position);
   assign cnt_w  = olist_pkg::CMP_W'(count_ff);
   assign full   = (count_ff == olist_pkg::COUNT_W'(olist_pkg::LIST_DEPTH));
   assign done   = busy_ff && (step_ff == olist_pkg::STEP_W'(olist_pkg::TREE_LEVELS));

   always_comb begin
      ok_ins = 1'b0;
      ok_del = 1'b0;
      ok_rd  = 1'b0;
      err_in = olist_pkg::ERR_RANGE;
      unique case (req_data.command)
         olist_pkg::CMD_INSERT: begin
            priority if (full) begin
               err_in = olist_pkg::ERR_FULL;
            end else if (pos_w > cnt_w) begin
               err_in = olist_pkg::ERR_RANGE;
            end else begin
               err_in = olist_pkg::ERR_OK;
               ok_ins = 1'b1;
            end
         end
         olist_pkg::CMD_DELETE: begin
            if (pos_w < cnt_w) begin
               err_in = olist_pkg::ERR_OK;
               ok_del = 1'b1;
            end
         end
         olist_pkg::CMD_READ: begin
            if (pos_w < cnt_w) begin
               err_in = olist_pkg::ERR_OK;
               ok_rd  = 1'b1;
            end
         end
         default: err_in = olist_pkg::ERR_RANGE;
      endcase
   end

   always_comb begin
      ctl.pos     = pos_w;
      ctl.value   = req_data.value_in;
      ctl.read_en = accept && (ok_del || ok_rd);
      priority if (accept && ok_ins) begin
         ctl.op = olist_pkg::OP_INSERT;
      end else if (accept && ok_del) begin
         ctl.op = olist_pkg::OP_DELETE;
      end else begin
         ctl.op = olist_pkg::OP_HOLD;
      end
   end

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
         if (ok_ins) begin
            count_in = count_ff + 1'b1;
         end else if (ok_del) begin
            count_in = count_ff - 1'b1;
         end
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff <= err_in;
      end
   end

   for (genvar i = 0; i < olist_pkg::LIST_DEPTH; i++) begin : g_cell
      logic [olist_pkg::DATA_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = req_data.value_in;
      end else begin : g_left
         assign left_d = cell_data[i-1];
      end
      if (i == olist_pkg::LIST_DEPTH - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_right
         assign right_d = cell_data[i+1];
      end
      olist_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (olist_pkg::IDX_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i]),
         .tap_out    (taps[i])
      );
   end

   olist_or_tree u_tree (
      .clock (clock),
      .taps  (taps),
      .root  (root)
   );

   assign busy                 = busy_ff;
   assign rsp_valid            = done;
   assign rsp_data.value_out   = root;
   assign rsp_data.error_code  = err_ff;
   assign rsp_data.entry_count = 8'(count_ff);
   assign rsp_data.is_empty    = (count_ff == '0);
   assign rsp_data.is_full     = full;

endmodule
